/* design/cau_pkg.sv */
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DIV_STEPS     = 16;   // quotient bits below the overflow check
    localparam int DEN_W         = 33;   // twice the squared magnitude of b

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [15:0] res_re;
        logic signed [15:0] res_im;
        logic               is_equal;
        logic               div_zero;
        logic               saturated;
    } rsp_t;

    // Per-item control that rides along the quotient pipeline
    typedef struct packed {
        logic run;      // divide with nonzero denominator
        logic dz;
        logic eq;
        logic neg_re;
        logic neg_im;
        logic big_re;   // magnitude at or above 2^16
        logic big_im;
    } side_t;

endpackage

/* design/complex_arith_unit.sv */
// Top level of the pipelined fixed-point complex ALU.
//
//   channel | signals                   | beat
//   --------+---------------------------+----------------------------------
//   request | req_valid req_ready req   | op and operands a, b (req_t)
//   result  | rsp_valid rsp_ready rsp   | result parts and flags (rsp_t)
//
// One beat enters per cycle unless the pipeline holds; every operation passes
// the same registers from acceptance to result: products, sums, setup, 16 restoring-divide stages
// and the rounding/clip register. Reset clears only the valid bits.
// The whole pipeline holds while the result register is full and not taken,
// so req_ready follows rsp_ready then; nothing is dropped or repeated.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int RW = FRAC_BITS + 50;
    localparam logic [32:0] HALF = (33'(1) << FRAC_BITS) >> 1;

    logic en;

    // stage 1: products and add/sub
    logic               v1_reg;
    logic [1:0]         op1_reg;
    logic               eq1_reg;
    logic signed [31:0] prr_reg, pii_reg, pri_reg, pir_reg, sqr_reg, sqi_reg;
    logic signed [16:0] sr_reg, si_reg;

    // stage 2: sign and magnitude
    logic               v2_reg;
    logic [1:0]         op2_reg;
    logic               eq2_reg;
    logic               nre2_reg, nim2_reg;
    logic [31:0]        mre2_reg, mim2_reg, d2_reg;

    // stage 3: divide setup
    logic               v3_reg;
    side_t              s3_reg;
    logic [RW-1:0]      rre3_reg, rim3_reg;
    logic [DEN_W-1:0]   den3_reg;
    logic [15:0]        qre3_reg, qim3_reg;

    // output
    logic               vo_reg;
    rsp_t               rsp_reg;

    assign en        = !vo_reg || rsp_ready;
    assign req_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= req.op;
            eq1_reg <= (req.a_re == req.b_re) && (req.a_im == req.b_im);
            prr_reg <= 32'($signed(req.a_re)) * 32'($signed(req.b_re));
            pii_reg <= 32'($signed(req.a_im)) * 32'($signed(req.b_im));
            pri_reg <= 32'($signed(req.a_re)) * 32'($signed(req.b_im));
            pir_reg <= 32'($signed(req.a_im)) * 32'($signed(req.b_re));
            sqr_reg <= 32'($signed(req.b_re)) * 32'($signed(req.b_re));
            sqi_reg <= 32'($signed(req.b_im)) * 32'($signed(req.b_im));
            if (req.op == OP_SUB)
            begin
                sr_reg <= 17'($signed(req.a_re)) - 17'($signed(req.b_re));
                si_reg <= 17'($signed(req.a_im)) - 17'($signed(req.b_im));
            end
            else
            begin
                sr_reg <= 17'($signed(req.a_re)) + 17'($signed(req.b_re));
                si_reg <= 17'($signed(req.a_im)) + 17'($signed(req.b_im));
            end
        end
    end

    // stage 2
    logic signed [32:0] xre, xim, nxre, nxim;

    always_comb
    begin
        case (op_t'(op1_reg))
            OP_MUL:
            begin
                xre = 33'(prr_reg) - 33'(pii_reg);
                xim = 33'(pir_reg) + 33'(pri_reg);
            end
            OP_DIV:
            begin
                xre = 33'(prr_reg) + 33'(pii_reg);
                xim = 33'(pir_reg) - 33'(pri_reg);
            end
            default:
            begin
                xre = 33'(sr_reg);
                xim = 33'(si_reg);
            end
        endcase
        nxre = -xre;
        nxim = -xim;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg  <= op1_reg;
            eq2_reg  <= eq1_reg;
            nre2_reg <= xre[32];
            nim2_reg <= xim[32];
            mre2_reg <= xre[32] ? nxre[31:0] : xre[31:0];
            mim2_reg <= xim[32] ? nxim[31:0] : xim[31:0];
            d2_reg   <= $unsigned(sqr_reg) + $unsigned(sqi_reg);
        end
    end

    // stage 3
    side_t            s3_next;
    logic [RW-1:0]    rre3_next, rim3_next, lim3;
    logic [DEN_W-1:0] den3_next;
    logic [15:0]      qre3_next, qim3_next;
    logic [32:0]      rnd_re, rnd_im;

    always_comb
    begin
        s3_next        = '0;
        s3_next.eq     = eq2_reg;
        s3_next.neg_re = nre2_reg;
        s3_next.neg_im = nim2_reg;
        den3_next      = DEN_W'(d2_reg) << 1;
        rre3_next      = '0;
        rim3_next      = '0;
        lim3           = RW'(den3_next) << DIV_STEPS;
        rnd_re         = (33'(mre2_reg) + HALF) >> FRAC_BITS;
        rnd_im         = (33'(mim2_reg) + HALF) >> FRAC_BITS;
        qre3_next      = mre2_reg[15:0];
        qim3_next      = mim2_reg[15:0];
        s3_next.big_re = |mre2_reg[31:16];
        s3_next.big_im = |mim2_reg[31:16];
        case (op_t'(op2_reg))
            OP_MUL:
            begin
                qre3_next      = rnd_re[15:0];
                qim3_next      = rnd_im[15:0];
                s3_next.big_re = |rnd_re[32:16];
                s3_next.big_im = |rnd_im[32:16];
            end
            OP_DIV:
            begin
                qre3_next = '0;
                qim3_next = '0;
                if (d2_reg == '0)
                begin
                    s3_next.dz     = 1'b1;
                    s3_next.big_re = 1'b0;
                    s3_next.big_im = 1'b0;
                end
                else
                begin
                    s3_next.run    = 1'b1;
                    rre3_next      = (RW'(mre2_reg) << (FRAC_BITS + 1)) + RW'(d2_reg);
                    rim3_next      = (RW'(mim2_reg) << (FRAC_BITS + 1)) + RW'(d2_reg);
                    s3_next.big_re = rre3_next >= lim3;
                    s3_next.big_im = rim3_next >= lim3;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg   <= s3_next;
            rre3_reg <= rre3_next;
            rim3_reg <= rim3_next;
            den3_reg <= den3_next;
            qre3_reg <= qre3_next;
            qim3_reg <= qim3_next;
        end
    end

    // quotient stages
    logic        vd;
    side_t       sd;
    logic [15:0] qre_d, qim_d;
    side_t       s3_run;

    always_comb
    begin
        s3_run     = s3_reg;
        // run stays set when the quotient already overflows; that lane enters with a zero remainder
        s3_run.run = s3_reg.run && !s3_reg.big_re && !s3_reg.big_im ? 1'b1 : 1'b0;
        if (s3_reg.run && (s3_reg.big_re || s3_reg.big_im))
        begin
            s3_run.run = 1'b1;
        end
    end

    cau_div_pipe #(
        .RW (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .v_in      (v3_reg),
        .side_in   (s3_run),
        .rem_re_in (s3_reg.big_re ? '0 : rre3_reg),
        .rem_im_in (s3_reg.big_im ? '0 : rim3_reg),
        .den_in    (den3_reg),
        .q_re_in   (qre3_reg),
        .q_im_in   (qim3_reg),
        .v_out     (vd),
        .side_out  (sd),
        .q_re_out  (qre_d),
        .q_im_out  (qim_d)
    );

    // sign and clip
    rsp_t        rsp_next;
    logic        sat_re, sat_im;
    logic [15:0] nq_re, nq_im;

    always_comb
    begin
        nq_re = 16'(0) - qre_d;
        nq_im = 16'(0) - qim_d;
        if (sd.neg_re)
        begin
            sat_re          = sd.big_re || qre_d > 16'h8000;
            rsp_next.res_re = sat_re ? 16'sh8000 : $signed(nq_re);
        end
        else
        begin
            sat_re          = sd.big_re || qre_d > 16'h7FFF;
            rsp_next.res_re = sat_re ? 16'sh7FFF : $signed(qre_d);
        end
        if (sd.neg_im)
        begin
            sat_im          = sd.big_im || qim_d > 16'h8000;
            rsp_next.res_im = sat_im ? 16'sh8000 : $signed(nq_im);
        end
        else
        begin
            sat_im          = sd.big_im || qim_d > 16'h7FFF;
            rsp_next.res_im = sat_im ? 16'sh7FFF : $signed(qim_d);
        end
        rsp_next.is_equal  = sd.eq;
        rsp_next.div_zero  = sd.dz;
        rsp_next.saturated = sat_re || sat_im;
        if (sd.dz)
        begin
            rsp_next.res_re    = '0;
            rsp_next.res_im    = '0;
            rsp_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= vd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = vo_reg;
    assign rsp       = rsp_reg;

endmodule

/* design/cau_div_pipe.sv */
// Restoring divider pipeline: one quotient bit per stage for both lanes.
module cau_div_pipe
    import cau_pkg::*;
#(
    parameter int RW = 58
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 v_in,
    input  side_t                side_in,
    input  logic [RW-1:0]        rem_re_in,
    input  logic [RW-1:0]        rem_im_in,
    input  logic [DEN_W-1:0]     den_in,
    input  logic [15:0]          q_re_in,
    input  logic [15:0]          q_im_in,
    output logic                 v_out,
    output side_t                side_out,
    output logic [15:0]          q_re_out,
    output logic [15:0]          q_im_out
);

    logic                 v_reg    [DIV_STEPS];
    side_t                side_reg [DIV_STEPS];
    logic [RW-1:0]        rre_reg  [DIV_STEPS];
    logic [RW-1:0]        rim_reg  [DIV_STEPS];
    logic [DEN_W-1:0]     den_reg  [DIV_STEPS];
    logic [15:0]          qre_reg  [DIV_STEPS];
    logic [15:0]          qim_reg  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int BIT  = DIV_STEPS - 1 - k;
        localparam int PREV = (k == 0) ? 0 : k - 1;

        logic             v_cur;
        side_t            s_cur;
        logic [RW-1:0]    rre_cur, rim_cur, sub_cur;
        logic [DEN_W-1:0] den_cur;
        logic [15:0]      qre_cur, qim_cur;
        logic [RW-1:0]    rre_next, rim_next;
        logic [15:0]      qre_next, qim_next;

        always_comb
        begin
            if (k == 0)
            begin
                v_cur   = v_in;
                s_cur   = side_in;
                rre_cur = rem_re_in;
                rim_cur = rem_im_in;
                den_cur = den_in;
                qre_cur = q_re_in;
                qim_cur = q_im_in;
            end
            else
            begin
                v_cur   = v_reg[PREV];
                s_cur   = side_reg[PREV];
                rre_cur = rre_reg[PREV];
                rim_cur = rim_reg[PREV];
                den_cur = den_reg[PREV];
                qre_cur = qre_reg[PREV];
                qim_cur = qim_reg[PREV];
            end
            sub_cur  = RW'(den_cur) << BIT;
            rre_next = rre_cur;
            rim_next = rim_cur;
            qre_next = qre_cur;
            qim_next = qim_cur;
            if (s_cur.run && rre_cur >= sub_cur)
            begin
                rre_next      = rre_cur - sub_cur;
                qre_next[BIT] = 1'b1;
            end
            if (s_cur.run && rim_cur >= sub_cur)
            begin
                rim_next      = rim_cur - sub_cur;
                qim_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= s_cur;
                rre_reg[k]  <= rre_next;
                rim_reg[k]  <= rim_next;
                den_reg[k]  <= den_cur;
                qre_reg[k]  <= qre_next;
                qim_reg[k]  <= qim_next;
            end
        end
    end

    assign v_out    = v_reg[DIV_STEPS-1];
    assign side_out = side_reg[DIV_STEPS-1];
    assign q_re_out = qre_reg[DIV_STEPS-1];
    assign q_im_out = qim_reg[DIV_STEPS-1];

endmodule

/* tb/complex_arith_unit_tb.sv */
// Testbench for the complex arithmetic unit: directed and random beats against a predictor.
`timescale 1ns / 1ps

module complex_arith_unit_tb;
    import cau_pkg::*;

    localparam int FRAC     = 8;
    localparam int LATENCY  = 20;
    localparam int LIMIT    = 200000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    rsp_t expected_q[$];
    int   mismatches;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_cycles;
    bit   failed;

    complex_arith_unit #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint clip_part(longint v, ref bit sat);
        if (v > 32767)
        begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // shift down by the fraction width, nearest, ties away from zero
    function automatic longint round_product(longint v);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint round_quotient(longint n, longint d);
        longint m;
        longint q;
        m = ((n < 0) ? -n : n) <<< FRAC;
        q = (2 * m + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic rsp_t complex_result(req_t r);
        rsp_t   o;
        longint ar;
        longint ai;
        longint br;
        longint bi;
        longint rr;
        longint ri;
        longint d;
        bit     sat;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        rr = 0;
        ri = 0;
        sat = 1'b0;
        o = '0;
        o.is_equal = (r.a_re == r.b_re) && (r.a_im == r.b_im);
        case (op_t'(r.op))
            OP_ADD:
            begin
                rr = clip_part(ar + br, sat);
                ri = clip_part(ai + bi, sat);
            end
            OP_SUB:
            begin
                rr = clip_part(ar - br, sat);
                ri = clip_part(ai - bi, sat);
            end
            OP_MUL:
            begin
                rr = clip_part(round_product(ar * br - ai * bi), sat);
                ri = clip_part(round_product(ai * br + ar * bi), sat);
            end
            default:
            begin
                d = br * br + bi * bi;
                if (d == 0)
                    o.div_zero = 1'b1;
                else
                begin
                    rr = clip_part(round_quotient(ar * br + ai * bi, d), sat);
                    ri = clip_part(round_quotient(ai * br - ar * bi, d), sat);
                end
            end
        endcase
        o.res_re = rr[15:0];
        o.res_im = ri[15:0];
        o.saturated = sat;
        return o;
    endfunction

    // valid stays high into the next beat unless the sender idles
    task automatic send_beat(op_t op, logic [15:0] ar, logic [15:0] ai,
                             logic [15:0] br, logic [15:0] bi);
        req_t r;
        r.op = op;
        r.a_re = ar;
        r.a_im = ai;
        r.b_re = br;
        r.b_im = bi;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_q.push_back(complex_result(r));
        @(negedge clk);
    endtask

    // mostly small values so products and quotients land in range
    function automatic logic [15:0] rand_part();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(1023)) - 512);
            2: return 16'($signed($urandom_range(8191)) - 4096);
            default: return 16'($signed($urandom_range(511)) - 256) << 4;
        endcase
    endfunction

    task automatic send_random(int n);
        logic [15:0] ar;
        logic [15:0] ai;
        for (int i = 0; i < n; i++)
        begin
            ar = rand_part();
            ai = rand_part();
            if ($urandom_range(15) == 0)
                send_beat(op_t'($urandom_range(3)), ar, ai, ar, ai);
            else if ($urandom_range(31) == 0)
                send_beat(op_t'($urandom_range(3)), ar, ai, 16'd0, 16'd0);
            else
                send_beat(op_t'($urandom_range(3)), ar, ai, rand_part(), rand_part());
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        logic [15:0] ext[5];
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0100};
        for (int o = 0; o < 4; o++)
        begin
            send_beat(op_t'(o), 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
            send_beat(op_t'(o), 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
            send_beat(op_t'(o), 16'h0100, 16'h0200, 16'h0000, 16'h0000);
            send_beat(op_t'(o), 16'h0180, 16'hfe80, 16'h0080, 16'h0001);
        end
        send_beat(OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
        send_beat(OP_DIV, 16'h0001, 16'h0000, 16'h0003, 16'h0000);
        send_beat(OP_MUL, 16'hffff, 16'hffff, 16'h0080, 16'h0080);
        for (int i = 0; i < 5; i++)
            send_beat(OP_MUL, ext[i], ext[4 - i], ext[(i + 2) % 5], ext[(i + 3) % 5]);
    endtask

    task automatic test_random_phases();
        int pct[4][2];
        pct = '{'{0, 0}, '{51, 0}, '{0, 51}, '{32, 32}};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = pct[p][0];
            recv_stall_pct = pct[p][1];
            send_random(90);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 60;
        send_random(30);
        drain();
        send_random(5);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
            begin
                failed <= 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat re=%h im=%h", rsp.res_re, rsp.res_im);
            end
            else
            begin
                if (rsp !== expected_q[0])
                begin
                    failed <= 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %b%b%b got %h %h %b%b%b",
                            expected_q[0].res_re, expected_q[0].res_im,
                            expected_q[0].is_equal, expected_q[0].div_zero,
                            expected_q[0].saturated, rsp.res_re, rsp.res_im,
                            rsp.is_equal, rsp.div_zero, rsp.saturated);
                end
                void'(expected_q.pop_front());
            end
        end
    end

    // receiver side: random stalls, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        failed = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (failed || mismatches != 0 || expected_q.size() != 0)
            $display("Regression FAIL");
        else
            $display("Regression PASS");
        $finish;
    end

endmodule
